>>> design/nqr_pkg.sv
`default_nettype none

package nqr_pkg;

	localparam int unsigned PixW   = 8;
	localparam int unsigned ProdW  = 19;
	localparam int unsigned TermW  = 9;
	localparam int unsigned SumW   = 10;
	localparam int unsigned Lanes  = 4;
	localparam int unsigned QShift = 10;

	localparam logic signed [ProdW-1:0] CoefRv = 19'sd1437;
	localparam logic signed [ProdW-1:0] CoefGu = 19'sd352;
	localparam logic signed [ProdW-1:0] CoefGv = 19'sd731;
	localparam logic signed [ProdW-1:0] CoefBu = 19'sd1812;
	localparam logic signed [ProdW-1:0] QRound = 19'sd1023;
	localparam logic [PixW-1:0]         ChanMax = 8'd255;

	typedef struct packed {
		logic signed [TermW-1:0] radd;
		logic signed [TermW-1:0] gsub;
		logic signed [TermW-1:0] badd;
	} term_t;

	typedef struct packed {
		logic [PixW-1:0] blue;
		logic [PixW-1:0] green;
		logic [PixW-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

	// divide by 1024, rounding toward zero
	function automatic logic signed [TermW-1:0] trunc_q10(input logic signed [ProdW-1:0] p);
		logic signed [ProdW-1:0] adj;
		begin
			adj = p + (p[ProdW-1] ? QRound : '0);
			return adj[ProdW-1:QShift];
		end
	endfunction

	function automatic logic [PixW-1:0] clamp_chan(input logic signed [SumW-1:0] s);
		begin
			if (s[SumW-1]) begin
				return '0;
			end else if (s[SumW-2]) begin
				return ChanMax;
			end else begin
				return s[PixW-1:0];
			end
		end
	endfunction

endpackage

`default_nettype wire

>>> design/nqr_chroma.sv
`default_nettype none

module nqr_chroma (
	input  wire logic                          clk,
	input  wire nqr_pkg::pipe_en_t             en,
	input  wire logic [nqr_pkg::PixW-1:0]      chroma_u,
	input  wire logic [nqr_pkg::PixW-1:0]      chroma_v,
	output nqr_pkg::term_t                     term_s2
);
	import nqr_pkg::*;

	logic signed [PixW-1:0]  u_ofs;
	logic signed [PixW-1:0]  v_ofs;
	logic signed [ProdW-1:0] u_ext;
	logic signed [ProdW-1:0] v_ext;
	logic signed [ProdW-1:0] prod_rv_s1;
	logic signed [ProdW-1:0] prod_gu_s1;
	logic signed [ProdW-1:0] prod_gv_s1;
	logic signed [ProdW-1:0] prod_bu_s1;
	logic signed [ProdW-1:0] gsum;

	// remove the 128 bias: flip the top bit
	assign u_ofs = $signed({~chroma_u[PixW-1], chroma_u[PixW-2:0]});
	assign v_ofs = $signed({~chroma_v[PixW-1], chroma_v[PixW-2:0]});
	assign u_ext = {{(ProdW-PixW){u_ofs[PixW-1]}}, u_ofs};
	assign v_ext = {{(ProdW-PixW){v_ofs[PixW-1]}}, v_ofs};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_rv_s1 <= v_ext * CoefRv;
			prod_gu_s1 <= u_ext * CoefGu;
			prod_gv_s1 <= v_ext * CoefGv;
			prod_bu_s1 <= u_ext * CoefBu;
		end
	end

	assign gsum = prod_gu_s1 + prod_gv_s1;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			term_s2.radd <= trunc_q10(prod_rv_s1);
			term_s2.gsub <= trunc_q10(gsum);
			term_s2.badd <= trunc_q10(prod_bu_s1);
		end
	end

endmodule

`default_nettype wire

>>> design/nqr_lane.sv
`default_nettype none

module nqr_lane (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [nqr_pkg::PixW-1:0]      luma,
	input  wire nqr_pkg::term_t                term,
	output nqr_pkg::pixel_t                    pix_s3
);
	import nqr_pkg::*;

	logic signed [SumW-1:0] luma_ext;
	logic signed [SumW-1:0] red_sum;
	logic signed [SumW-1:0] green_sum;
	logic signed [SumW-1:0] blue_sum;

	assign luma_ext  = $signed({{(SumW-PixW){1'b0}}, luma});
	assign red_sum   = luma_ext + {term.radd[TermW-1], term.radd};
	assign green_sum = luma_ext - {term.gsub[TermW-1], term.gsub};
	assign blue_sum  = luma_ext + {term.badd[TermW-1], term.badd};

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s3.red   <= clamp_chan(red_sum);
			pix_s3.green <= clamp_chan(green_sum);
			pix_s3.blue  <= clamp_chan(blue_sum);
		end
	end

endmodule

`default_nettype wire

>>> design/nv21_quad_to_rgb.sv
// channel   dir  bits  contents
// s_axis    in   48    luma tl, tr, bl, br, chroma u, chroma v
// m_axis    out  96    r,g,b of tl, then tr, bl, br
//
// Three register stages: chroma products, chroma terms, per-pixel add and clamp.
// One quad per clock sustained while m_tready is high; m_tvalid follows valid_s3.
// Each stage advances when it is empty or the stage after it advances, so
// empty stages keep taking quads while a result waits on m_tready.
// arst_n clears the stage valid flags only; data registers hold no reset.
`default_nettype none

module nv21_quad_to_rgb (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [7:0] luma_top_left, [15:8] luma_top_right, [23:16] luma_bottom_left,
	// [31:24] luma_bottom_right, [39:32] chroma_u, [47:40] chroma_v
	input  wire logic [47:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] red_tl, [15:8] green_tl, [23:16] blue_tl, [31:24] red_tr,
	// [39:32] green_tr, [47:40] blue_tr, [55:48] red_bl, [63:56] green_bl,
	// [71:64] blue_bl, [79:72] red_br, [87:80] green_br, [95:88] blue_br
	output logic [95:0]      m_tdata
);
	import nqr_pkg::*;

	pipe_en_t        en;
	logic            valid_s1;
	logic            valid_s2;
	logic            valid_s3;
	logic [PixW-1:0] luma_s1 [Lanes];
	logic [PixW-1:0] luma_s2 [Lanes];
	term_t           term_s2;
	pixel_t          pix_s3 [Lanes];

	assign en.s3    = ~valid_s3 | m_tready;
	assign en.s2    = ~valid_s2 | en.s3;
	assign en.s1    = ~valid_s1 | en.s2;
	assign s_tready = en.s1;
	assign m_tvalid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= s_tvalid;
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < Lanes; i++) begin
			if (en.s1) luma_s1[i] <= s_tdata[i*PixW +: PixW];
			if (en.s2) luma_s2[i] <= luma_s1[i];
		end
	end

	nqr_chroma u_chroma (
		.clk      (clk),
		.en       (en),
		.chroma_u (s_tdata[Lanes*PixW +: PixW]),
		.chroma_v (s_tdata[(Lanes+1)*PixW +: PixW]),
		.term_s2  (term_s2)
	);

	for (genvar g = 0; g < Lanes; g++) begin : g_lane
		nqr_lane u_lane (
			.clk    (clk),
			.en     (en.s3),
			.luma   (luma_s2[g]),
			.term   (term_s2),
			.pix_s3 (pix_s3[g])
		);
		assign m_tdata[g*3*PixW +: PixW]          = pix_s3[g].red;
		assign m_tdata[g*3*PixW + PixW +: PixW]   = pix_s3[g].green;
		assign m_tdata[g*3*PixW + 2*PixW +: PixW] = pix_s3[g].blue;
	end

	a_ready_on_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output drains");

	a_ready_on_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s3 |-> s_tready)
		else $error("input stalled with empty output stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted transaction lost at first stage");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !m_tready |=> valid_s3)
		else $error("pending result dropped");

endmodule

`default_nettype wire

>>> bench/tb_nv21_quad_to_rgb.sv
`default_nettype none

module tb_nv21_quad_to_rgb;

	localparam int RvQ10      = 1437;
	localparam int GuQ10      = 352;
	localparam int GvQ10      = 731;
	localparam int BuQ10      = 1812;
	localparam int Q10Div     = 1024;
	localparam int ChromaBias = 128;
	localparam int ChanTop    = 255;
	localparam int RandQuads  = 1300;
	localparam int HoldCycles = 80;
	localparam int StuckLimit = 2000;
	localparam int DrainWait  = 10;

	typedef struct {
		logic [47:0] quad;
		bit          typed;
		logic [95:0] rgb;
	} quad_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;

	logic [95:0] rgb_due[$];
	quad_row_t   directed_rows[$];
	int          quads_sent;
	int          mismatches;
	int          stuck_cycles;

	nv21_quad_to_rgb dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [7:0] sat8(input int x);
		if (x < 0) begin
			return 8'd0;
		end
		if (x > ChanTop) begin
			return 8'd255;
		end
		return x[7:0];
	endfunction

	function automatic logic [95:0] quad_rgb(input logic [47:0] quad);
		int u;
		int v;
		int y;
		int radd;
		int gsub;
		int badd;
		logic [95:0] rgb;
		u = int'(quad[39:32]) - ChromaBias;
		v = int'(quad[47:40]) - ChromaBias;
		radd = (RvQ10 * v) / Q10Div;
		gsub = (GuQ10 * u + GvQ10 * v) / Q10Div;
		badd = (BuQ10 * u) / Q10Div;
		for (int k = 0; k < 4; k++) begin
			y = int'(quad[8*k +: 8]);
			rgb[24*k      +: 8] = sat8(y + radd);
			rgb[24*k + 8  +: 8] = sat8(y - gsub);
			rgb[24*k + 16 +: 8] = sat8(y + badd);
		end
		return rgb;
	endfunction

	function automatic logic [95:0] rgb4(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {4{b, g, r}};
	endfunction

	function automatic quad_row_t table_row(input logic [7:0] ytl, input logic [7:0] ytr,
			input logic [7:0] ybl, input logic [7:0] ybr, input logic [7:0] u,
			input logic [7:0] v, input bit typed, input logic [95:0] rgb);
		quad_row_t row;
		row.quad  = {v, u, ybr, ybl, ytr, ytl};
		row.typed = typed;
		row.rgb   = rgb;
		return row;
	endfunction

	function automatic logic [7:0] chroma_or_luma_byte();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'(ChromaBias + $urandom_range(0, 4) - 2);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic bit calm_stretch();
		return quads_sent >= 500 && quads_sent < 700;
	endfunction

	task automatic offer_quad(input logic [47:0] quad);
		while (!calm_stretch() && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 48'({$urandom, $urandom});
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= quad;
		do begin
			@(posedge clk);
		end while (!s_tready);
		quads_sent++;
	endtask

	initial begin
		logic [47:0] quad;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		quads_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_rows.push_back(table_row(0, 0, 0, 0, 128, 128, 1, rgb4(0, 0, 0)));
		directed_rows.push_back(table_row(255, 255, 255, 255, 128, 128, 1,
			rgb4(255, 255, 255)));
		directed_rows.push_back(table_row(100, 100, 100, 100, 128, 128, 1,
			rgb4(100, 100, 100)));
		// negative terms round toward zero
		directed_rows.push_back(table_row(100, 100, 100, 100, 127, 127, 1,
			rgb4(99, 101, 99)));
		directed_rows.push_back(table_row(100, 100, 100, 100, 129, 129, 1,
			rgb4(101, 99, 101)));
		directed_rows.push_back(table_row(255, 255, 255, 255, 255, 255, 1,
			rgb4(255, 121, 255)));
		directed_rows.push_back(table_row(0, 0, 0, 0, 0, 0, 1, rgb4(0, 135, 0)));
		directed_rows.push_back(table_row(255, 255, 255, 255, 0, 0, 1, rgb4(76, 255, 29)));
		directed_rows.push_back(table_row(0, 0, 0, 0, 255, 255, 1, rgb4(178, 0, 224)));
		directed_rows.push_back(table_row(0, 255, 0, 255, 0, 255, 0, '0));
		directed_rows.push_back(table_row(255, 0, 255, 0, 255, 0, 0, '0));
		directed_rows.push_back(table_row(8'h55, 8'haa, 8'h0f, 8'hf0, 8'h80, 8'h7f, 0, '0));
		directed_rows.push_back(table_row(8'haa, 8'h55, 8'hf0, 8'h0f, 8'h7f, 8'h80, 0, '0));
		directed_rows.push_back(table_row(200, 10, 128, 60, 255, 128, 0, '0));
		directed_rows.push_back(table_row(30, 220, 90, 160, 128, 0, 0, '0));
		directed_rows.push_back(table_row(1, 254, 127, 128, 64, 192, 0, '0));

		foreach (directed_rows[i]) begin
			offer_quad(directed_rows[i].quad);
			rgb_due.push_back(directed_rows[i].typed ? directed_rows[i].rgb
				: quad_rgb(directed_rows[i].quad));
		end

		for (int i = 0; i < RandQuads; i++) begin
			for (int f = 0; f < 6; f++) begin
				quad[8*f +: 8] = chroma_or_luma_byte();
			end
			offer_quad(quad);
			rgb_due.push_back(quad_rgb(quad));
		end
		s_tvalid <= 1'b0;

		while (rgb_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainWait) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_nv21_quad_to_rgb: clean");
		end else begin
			$display("tb_nv21_quad_to_rgb: errors");
		end
		$finish;
	end

	// receiver: random stalls, one long hold-off to back up the pipeline
	initial begin
		int  hold_left;
		bit  held_once;
		hold_left = 0;
		held_once = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held_once && quads_sent >= 300) begin
				held_once = 1;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm_stretch()) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 33);
			end
		end
	end

	always @(posedge clk) begin
		logic [95:0] due;
		string       corner;
		string       chan;
		if (arst_n && m_tvalid && m_tready) begin
			if (rgb_due.size() == 0) begin
				$display("%0t: RGB transaction with no quad pending, actual %h", $time, m_tdata);
				mismatches++;
			end else begin
				due = rgb_due.pop_front();
				for (int k = 0; k < 12; k++) begin
					if (due[8*k +: 8] !== m_tdata[8*k +: 8]) begin
						corner = (k / 3 == 0) ? "tl" : (k / 3 == 1) ? "tr"
							: (k / 3 == 2) ? "bl" : "br";
						chan = (k % 3 == 0) ? "red" : (k % 3 == 1) ? "green" : "blue";
						$display("%0t: %s_%s expected %0d, actual %0d", $time, chan, corner,
							due[8*k +: 8], m_tdata[8*k +: 8]);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= StuckLimit) begin
			$display("%0t: no transaction for %0d cycles", $time, StuckLimit);
			$display("tb_nv21_quad_to_rgb: errors");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

endmodule

`default_nettype wire

>>> sim.f
design/nqr_pkg.sv
design/nqr_chroma.sv
design/nqr_lane.sv
design/nv21_quad_to_rgb.sv
bench/tb_nv21_quad_to_rgb.sv
